### hdl/knap_pkg.sv
// shared types and constants for the knapsack solver core
// no dependencies; used by every module under hdl except knap_ram
package knap_pkg;

    // fixed field widths
    localparam int VALUE_W  = 16;
    localparam int WEIGHT_W = 10;
    localparam int CAP_W    = 10;
    localparam int RESULT_W = 32;

    // parameter defaults
    localparam int CAPACITY_MAX_DEF = 1023;
    localparam int VALUE_BITS_DEF   = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // what the back has to do with one queued item
    typedef enum logic [1:0] {
        KIND_EMPTY,   // capacity zero: result is zero, row untouched
        KIND_PROBE,   // item cannot fit: only best[capacity] is read
        KIND_SWEEP    // full walk from capacity down to 1
    } item_kind_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
        item_kind_t          kind;
    } item_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SWEEP,
        BK_DRAIN
    } back_state_t;

    typedef struct packed {
        logic clearing;
        logic draining;
    } back_status_t;

endpackage

### hdl/knap_ram.sv
// generic single-write, dual-read ram with registered read data
// no dependencies
module knap_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [WIDTH-1:0]  rdata_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hdl/knap_front.sv
// front end: accepts items, classifies them and queues the ones the back end needs
// depends on knap_pkg
module knap_front #(
    parameter int ADDR_W     = 10,
    parameter int VALUE_BITS = knap_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [knap_pkg::VALUE_W-1:0]  item_value,
    input  logic [knap_pkg::WEIGHT_W-1:0] item_weight,
    input  logic                         last_item,
    input  logic [ADDR_W-1:0]            cap,
    input  logic                         hold,
    output logic                         busy,
    output logic                         head_valid,
    output knap_pkg::item_t              head,
    input  logic                         pop
);

    localparam int CMP_W  = (ADDR_W > knap_pkg::WEIGHT_W) ? ADDR_W : knap_pkg::WEIGHT_W;
    localparam int QPTR_W = (knap_pkg::QUEUE_DEPTH > 1) ? $clog2(knap_pkg::QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(knap_pkg::QUEUE_DEPTH + 1);
    localparam logic [knap_pkg::VALUE_W-1:0] VALUE_MASK =
        (VALUE_BITS >= knap_pkg::VALUE_W) ? {knap_pkg::VALUE_W{1'b1}}
                                          : knap_pkg::VALUE_W'((33'd1 << VALUE_BITS) - 33'd1);

    knap_pkg::item_t   q_reg [knap_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    knap_pkg::item_t   item;
    logic              accept;
    logic              push;
    logic              full;

    // mask the value and classify the incoming item against the effective capacity
    always_comb
    begin
        item.value  = item_value & VALUE_MASK;
        item.weight = item_weight;
        item.last   = last_item;
        if (cap == '0)
        begin
            item.kind = knap_pkg::KIND_EMPTY;
        end
        else if (CMP_W'(item_weight) > CMP_W'(cap))
        begin
            item.kind = knap_pkg::KIND_PROBE;
        end
        else
        begin
            item.kind = knap_pkg::KIND_SWEEP;
        end
    end

    assign full   = (count_reg == QCNT_W'(knap_pkg::QUEUE_DEPTH));
    assign busy   = full || hold;
    assign accept = start && !busy;
    // items that change nothing and give no result are dropped
    assign push   = accept && (last_item || (item.kind == knap_pkg::KIND_SWEEP));

    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(knap_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(knap_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

### hdl/knap_back.sv
// back end: walks the row of best values for each fitting item and clears it
// depends on knap_pkg and knap_ram
module knap_back #(
    parameter int CAPACITY_MAX = knap_pkg::CAPACITY_MAX_DEF,
    parameter int ADDR_W       = $clog2(CAPACITY_MAX + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ADDR_W-1:0]             cap,
    input  logic                          head_valid,
    input  knap_pkg::item_t               head,
    output logic                          pop,
    output logic                          done,
    output logic [knap_pkg::RESULT_W-1:0] best_value,
    output knap_pkg::back_status_t        stat
);

    localparam int ROW_DEPTH = CAPACITY_MAX + 1;
    localparam int CMP_W     = (ADDR_W > knap_pkg::WEIGHT_W) ? ADDR_W : knap_pkg::WEIGHT_W;
    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(CAPACITY_MAX);

    knap_pkg::back_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]             j_reg, j_next;
    knap_pkg::item_t               cur_reg;
    logic                          s1_valid_reg;
    logic [ADDR_W-1:0]             s1_addr_reg;
    logic                          s1_take_reg;
    logic                          s1_first_reg;
    logic [knap_pkg::RESULT_W-1:0] result_reg;
    logic                          done_reg, done_next;
    logic                          zero_result;
    logic                          issue;
    logic                          take;
    logic [CMP_W-1:0]              jx, wx;
    logic [ADDR_W-1:0]             raddr_b;
    logic [knap_pkg::RESULT_W-1:0] rdata_a, rdata_b;
    logic [knap_pkg::RESULT_W:0]   sum;
    logic [knap_pkg::RESULT_W-1:0] cand, newv;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [knap_pkg::RESULT_W-1:0] ram_wdata;

    // read addresses for entry j and entry j - w (entry j when the item does not fit)
    assign jx      = CMP_W'(j_reg);
    assign wx      = CMP_W'(cur_reg.weight);
    assign take    = (wx <= jx);
    assign raddr_b = take ? ADDR_W'(jx - wx) : j_reg;

    // saturating candidate and max against the current entry
    assign sum  = {1'b0, rdata_b} + (knap_pkg::RESULT_W + 1)'(cur_reg.value);
    assign cand = sum[knap_pkg::RESULT_W] ? '1 : sum[knap_pkg::RESULT_W-1:0];
    assign newv = (s1_take_reg && (cand > rdata_a)) ? cand : rdata_a;

    // write port: clearing pass or update stage
    always_comb
    begin
        if (state_reg == knap_pkg::BK_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = j_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_valid_reg;
            ram_waddr = s1_addr_reg;
            ram_wdata = newv;
        end
    end

    knap_ram #(
        .WIDTH  (knap_pkg::RESULT_W),
        .DEPTH  (ROW_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_row (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (j_reg),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        j_next      = j_reg;
        pop         = 1'b0;
        issue       = 1'b0;
        done_next   = 1'b0;
        zero_result = 1'b0;
        unique case (state_reg)
            knap_pkg::BK_CLEAR:
            begin
                if (j_reg == '0)
                begin
                    state_next = knap_pkg::BK_IDLE;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                end
            end
            knap_pkg::BK_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head.kind == knap_pkg::KIND_EMPTY)
                    begin
                        zero_result = 1'b1;
                        done_next   = 1'b1;
                        state_next  = knap_pkg::BK_CLEAR;
                        j_next      = TOP_ADDR;
                    end
                    else
                    begin
                        state_next = knap_pkg::BK_SWEEP;
                        j_next     = cap;
                    end
                end
            end
            knap_pkg::BK_SWEEP:
            begin
                issue = 1'b1;
                if ((cur_reg.kind == knap_pkg::KIND_PROBE) || (j_reg == ADDR_W'(1)))
                begin
                    state_next = knap_pkg::BK_DRAIN;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                end
            end
            knap_pkg::BK_DRAIN:
            begin
                if (cur_reg.last)
                begin
                    done_next  = 1'b1;
                    state_next = knap_pkg::BK_CLEAR;
                    j_next     = TOP_ADDR;
                end
                else
                begin
                    state_next = knap_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = knap_pkg::BK_CLEAR;
                j_next     = TOP_ADDR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= knap_pkg::BK_CLEAR;
            j_reg        <= TOP_ADDR;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            j_reg        <= j_next;
            s1_valid_reg <= issue;
            done_reg     <= done_next;
        end
    end

    // payload: current item, update stage and result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        s1_addr_reg  <= j_reg;
        s1_take_reg  <= take;
        s1_first_reg <= (j_reg == cap);
        if (zero_result)
        begin
            result_reg <= '0;
        end
        else if (s1_valid_reg && s1_first_reg)
        begin
            result_reg <= newv;
        end
    end

    assign done          = done_reg;
    assign best_value    = result_reg;
    assign stat.clearing = (state_reg == knap_pkg::BK_CLEAR);
    assign stat.draining = (state_reg == knap_pkg::BK_DRAIN);

endmodule

### hdl/zero_one_knapsack_solver_core.sv
// top level of the 0/1 knapsack solver: capacity register, front end, back end
// depends on knap_pkg, knap_front, knap_back (which holds knap_ram)
//
// channel   direction  handshake                 payload
// item      in         start && !busy            item_value, item_weight, last_item
// result    out        done (one-cycle strobe)   best_value
// capacity  in         capacity_we               capacity_wdata
//
// an item that updates the row is loaded in the back end, then gets one read-modify-write
// per entry from C down to 1 over the two-read row ram, then a drain, C being the
// effective capacity; an item that cannot fit and is last reads entry C, then drains.
// after a last item the row's CAPACITY_MAX + 1 entries are cleared, one entry per cycle;
// the same clearing pass runs after reset. busy is high while clearing or queue is full.
// results cannot be stalled: done is high for one cycle, as the clearing pass starts.
module zero_one_knapsack_solver_core #(
    parameter int CAPACITY_MAX = knap_pkg::CAPACITY_MAX_DEF,
    parameter int VALUE_BITS   = knap_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [knap_pkg::VALUE_W-1:0]  item_value,
    input  logic [knap_pkg::WEIGHT_W-1:0] item_weight,
    input  logic                          last_item,
    output logic                          done,
    output logic [knap_pkg::RESULT_W-1:0] best_value,
    input  logic                          capacity_we,
    input  logic [knap_pkg::CAP_W-1:0]    capacity_wdata
);

    localparam int ADDR_W = $clog2(CAPACITY_MAX + 1);

    logic [knap_pkg::CAP_W-1:0] capacity_reg;
    logic [ADDR_W-1:0]          cap_eff;
    logic                       head_valid;
    knap_pkg::item_t            head;
    logic                       pop;
    knap_pkg::back_status_t     back_stat;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else if (capacity_we)
        begin
            capacity_reg <= capacity_wdata;
        end
    end

    // effective capacity saturates at CAPACITY_MAX, the top entry of the row
    assign cap_eff = (32'(capacity_reg) > 32'(CAPACITY_MAX)) ? ADDR_W'(CAPACITY_MAX)
                                                            : ADDR_W'(capacity_reg);

    knap_front #(
        .ADDR_W     (ADDR_W),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item_value  (item_value),
        .item_weight (item_weight),
        .last_item   (last_item),
        .cap         (cap_eff),
        .hold        (back_stat.clearing),
        .busy        (busy),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop)
    );

    knap_back #(
        .CAPACITY_MAX (CAPACITY_MAX),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cap        (cap_eff),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .best_value (best_value),
        .stat       (back_stat)
    );

    // result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // the row is being cleared in every cycle that gives a result
    assert property (@(posedge clk) disable iff (!rst_n) done |-> back_stat.clearing)
        else $error("result transaction without row clearing");

    // no new item is taken while the row is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) back_stat.clearing |-> busy)
        else $error("input accepted during row clearing");

    // drain of the update stage is a single cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.draining |=> !back_stat.draining)
        else $error("drain state held for more than one cycle");

endmodule

### tb/knap_row_check_pkg.sv
// row predictor and result scoreboard for the knapsack solver core testbench
// depends on knap_pkg for field widths and the default capacity limit
`timescale 1ns / 100ps
package knap_row_check_pkg;

    localparam int CAP_LIMIT  = knap_pkg::CAPACITY_MAX_DEF;
    localparam int VALUE_BITS = knap_pkg::VALUE_BITS_DEF;
    localparam int REPORT_MAX = 10;

    class knap_row_predictor;
        logic [knap_pkg::RESULT_W-1:0] best_row [0:CAP_LIMIT];
        int unsigned                   capacity;
        logic [knap_pkg::RESULT_W-1:0] expected_best [$];
        int                            mismatches;

        function new();
            clear_row();
            capacity   = 0;
            mismatches = 0;
        endfunction

        function void clear_row();
            for (int j = 0; j <= CAP_LIMIT; j++)
                best_row[j] = '0;
        endfunction

        function void set_capacity(logic [knap_pkg::CAP_W-1:0] cap);
            capacity = 32'(cap);
        endfunction

        function int unsigned limited_capacity();
            return (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
        endfunction

        function int pending();
            return expected_best.size();
        endfunction

        // one accepted item transaction: in-place row update, high to low
        function void take_item(logic [knap_pkg::VALUE_W-1:0]  value,
                                logic [knap_pkg::WEIGHT_W-1:0] weight,
                                logic                          last);
            int unsigned                   cap;
            logic [knap_pkg::RESULT_W:0]   cand;
            logic [knap_pkg::RESULT_W-1:0] used_value;
            cap        = limited_capacity();
            used_value = 32'(value) & 32'((33'd1 << VALUE_BITS) - 33'd1);
            for (int j = cap; j >= 1; j--) begin
                if (weight <= j) begin
                    cand = {1'b0, best_row[j - weight]} + used_value;
                    // saturate at the 32-bit maximum
                    if (cand[knap_pkg::RESULT_W])
                        cand = {1'b0, {knap_pkg::RESULT_W{1'b1}}};
                    if (cand[knap_pkg::RESULT_W-1:0] > best_row[j])
                        best_row[j] = cand[knap_pkg::RESULT_W-1:0];
                end
            end
            // last item closes the problem: answer then fresh row
            if (last) begin
                expected_best.push_back(best_row[cap]);
                clear_row();
            end
        endfunction

        // one result transaction against the oldest expected answer
        function void check_best(logic [knap_pkg::RESULT_W-1:0] actual);
            logic [knap_pkg::RESULT_W-1:0] want_best;
            if (expected_best.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result transaction: best_value=%0d", actual);
            end
            else begin
                want_best = expected_best.pop_front();
                if (actual !== want_best) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("best_value mismatch: expected %0d, got %0d",
                                 want_best, actual);
                end
            end
        endfunction
    endclass

endpackage

### tb/zero_one_knapsack_solver_core_test.sv
// regression for zero_one_knapsack_solver_core: directed and random item streams,
// answers checked against a row predictor; depends on knap_pkg and knap_row_check_pkg
`timescale 1ns / 100ps
module zero_one_knapsack_solver_core_test;
    import knap_pkg::*;
    import knap_row_check_pkg::*;

    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int ITEM_TARGET  = 580;
    localparam logic [VALUE_W-1:0] VALUE_TOP = '1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = '1;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [VALUE_W-1:0]  item_value;
    logic [WEIGHT_W-1:0] item_weight;
    logic                last_item;
    logic                done;
    logic [RESULT_W-1:0] best_value;
    logic                capacity_we;
    logic [CAP_W-1:0]    capacity_wdata;

    knap_row_predictor row_model;
    int                items_sent;
    int                burst_left;
    int                cycle_count;

    zero_one_knapsack_solver_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item_value     (item_value),
        .item_weight    (item_weight),
        .last_item      (last_item),
        .done           (done),
        .best_value     (best_value),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result transactions, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            row_model.check_best(best_value);
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("zero_one_knapsack_solver_core regression: fail");
            $finish;
        end
    end

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // one item transaction; sender works in bursts with random gaps
    task automatic send_item(logic [VALUE_W-1:0] value, logic [WEIGHT_W-1:0] weight,
                             logic last);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
                idle_cycles(gap);
            burst_left = $urandom_range(1, 12);
        end
        start       <= 1'b1;
        item_value  <= value;
        item_weight <= weight;
        last_item   <= last;
        do
            @(posedge clk);
        while (busy);
        row_model.take_item(value, weight, last);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // wait for every answer, then for any queued non-last items and the clear pass
    task automatic wait_quiet();
        int settle;
        start <= 1'b0;
        while (row_model.pending() != 0)
            @(negedge clk);
        settle = 3 * (row_model.limited_capacity() + 3) + CAP_LIMIT + 1 + 16;
        repeat (settle) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        wait_quiet();
        capacity_we    <= 1'b1;
        capacity_wdata <= cap;
        @(negedge clk);
        capacity_we <= 1'b0;
        row_model.set_capacity(cap);
    endtask

    // mostly small capacities; large ones are slow
    function automatic logic [CAP_W-1:0] pick_capacity();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return CAP_W'($urandom_range(0, CAP_LIMIT));
        else if (r == 1)
            return '0;
        else if (r <= 5)
            return CAP_W'($urandom_range(41, 200));
        else
            return CAP_W'($urandom_range(1, 40));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        else if (r == 1)
            return VALUE_TOP;
        else
            return VALUE_W'($urandom);
    endfunction

    // weights that mostly fit, some zero, some just over capacity
    function automatic logic [WEIGHT_W-1:0] pick_weight(int unsigned cap);
        int r;
        int unsigned w;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        else if (r == 1) begin
            w = cap + $urandom_range(1, 8);
            return (w > CAP_LIMIT) ? WEIGHT_TOP : WEIGHT_W'(w);
        end
        else
            return WEIGHT_W'($urandom_range(0, cap));
    endfunction

    // one problem; noise problems use weights from the full field range
    task automatic run_problem(bit well_formed);
        int                  n;
        logic [WEIGHT_W-1:0] weight;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            // capacity change in mid-problem
            if (well_formed && i > 0 && $urandom_range(0, 11) == 0)
                write_capacity(pick_capacity());
            if (well_formed)
                weight = pick_weight(row_model.limited_capacity());
            else
                weight = WEIGHT_W'($urandom_range(0, CAP_LIMIT));
            send_item(pick_value(), weight, i == n - 1);
        end
    endtask

    initial
    begin
        row_model      = new();
        items_sent     = 0;
        burst_left     = 0;
        cycle_count    = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        item_value     = '0;
        item_weight    = '0;
        last_item      = 1'b0;
        capacity_we    = 1'b0;
        capacity_wdata = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // capacity zero straight after reset: answer is zero
        send_item(16'd5, '0, 1'b1);
        send_item(VALUE_TOP, WEIGHT_TOP, 1'b1);

        // small capacity: weight zero, fitting item, item over capacity
        write_capacity(10'd10);
        send_item(VALUE_TOP, '0, 1'b0);
        send_item(16'd100, 10'd3, 1'b0);
        send_item(16'd7, 10'd11, 1'b0);
        send_item(16'd50, 10'd10, 1'b1);
        send_item('0, 10'd4, 1'b1);

        // full capacity with extreme fields
        write_capacity(10'd1023);
        send_item(VALUE_TOP, WEIGHT_TOP, 1'b0);
        send_item(16'd1, '0, 1'b0);
        send_item(VALUE_TOP, 10'd512, 1'b1);

        // capacity shrinks then grows inside one problem
        write_capacity(10'd20);
        send_item(16'd9, 10'd15, 1'b0);
        write_capacity(10'd4);
        send_item(16'd2, 10'd1, 1'b0);
        write_capacity(10'd20);
        send_item(16'd1, 10'd5, 1'b1);

        // capacity one, all weights zero or one
        write_capacity(10'd1);
        send_item(16'd30, 10'd1, 1'b0);
        send_item(16'd40, 10'd1, 1'b0);
        send_item(16'd12, '0, 1'b1);

        // random phases, each starting with a new capacity setting
        while (items_sent < ITEM_TARGET) begin
            write_capacity(pick_capacity());
            repeat ($urandom_range(2, 6))
                run_problem($urandom_range(0, 9) != 0);
        end

        wait_quiet();
        if (row_model.mismatches == 0 && row_model.pending() == 0)
            $display("zero_one_knapsack_solver_core regression: pass");
        else
            $display("zero_one_knapsack_solver_core regression: fail");
        $finish;
    end

endmodule
